[hdl/eyfz_pkg.sv]
// Shared constants, word types and arithmetic helpers for the Euler frame converter.
package eyfz_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int ROT_W        = 20;
    localparam int VEC_W        = 22;
    localparam int Z_W          = 34;
    localparam int MUL_W        = 24;
    localparam int GAIN_Q16     = 39797;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] in_yaw;
        logic signed [ANGLE_BITS-1:0] in_pitch;
        logic signed [ANGLE_BITS-1:0] in_roll;
    } t_in_word;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] out_yaw;
        logic signed [ANGLE_BITS-1:0] out_pitch;
        logic signed [ANGLE_BITS-1:0] out_roll;
    } t_out_word;

    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Signed Q7.16 product with rounding; the shift floors.
    function automatic logic signed [MUL_W-1:0] qmul(input logic signed [MUL_W-1:0] a,
                                                      input logic signed [MUL_W-1:0] b);
        logic signed [2*MUL_W-1:0] p;
        p = (2*MUL_W)'(a) * (2*MUL_W)'(b) + (2*MUL_W)'(32768);
        return p[MUL_W+15:16];
    endfunction

endpackage

[hdl/euler_yzx_flip_to_euler_zxy_unit.sv]
// Top level of the Euler angle frame converter (Y-Z-X source, Y/Z flip, Z-X-Y result).
//
// The input channel (i_valid, o_ready, i_data) takes one word of source yaw, pitch
// and roll; the output channel (o_valid, i_ready, o_data) returns one word of
// converted yaw, pitch and roll for each input word, in order.
// Angles are binary angles in which half of the range stands for pi.
// A word passes through the sine and cosine CORDIC, three multiply stages, the
// yaw/roll vectoring CORDIC, the pitch vectoring CORDIC, and the output register.
// Throughput is one word per cycle while the output is not stalled; every CORDIC
// iteration is its own stage.
// The whole pipeline advances together whenever the output register is empty or
// being read, so when the receiver stalls with a word waiting, o_ready drops and
// every stage holds its contents; nothing is lost or repeated.
// A synchronous reset clears all valid bits; the block holds no other state and
// is ready for a word in the first cycle after reset.
module euler_yzx_flip_to_euler_zxy_unit #(
    parameter int CORDIC_STEPS = eyfz_pkg::CORDIC_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  eyfz_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output eyfz_pkg::t_out_word  o_data
);
    localparam int AB = eyfz_pkg::ANGLE_BITS;
    localparam int RW = eyfz_pkg::ROT_W;
    localparam int VW = eyfz_pkg::VEC_W;
    localparam int MW = eyfz_pkg::MUL_W;
    localparam logic [31:0] HALF = 32'(1) << (31 - AB);

    logic w_en;
    logic w_rv_y, w_rv_p, w_rv_r;
    logic signed [RW-1:0] w_cy, w_sy, w_cp, w_sp, w_cr, w_sr;

    logic r_v1, r_v2, r_v3;
    logic signed [MW-1:0] r1_f00, r1_f20, r1_spsy, r1_f10, r1_cp, r1_cr, r1_sr;
    logic signed [MW-1:0] r2_f00, r2_f10, r2_f20, r2_p1, r2_p2, r2_p3, r2_p4;
    logic signed [VW-1:0] r3_f00, r3_f10, r3_nf20, r3_f21, r3_f22;

    logic                 w_yv, w_rv;
    logic [31:0]          w_yaw, w_roll;
    logic signed [VW-1:0] w_mag, w_nf20, w_mag_unused_r;
    logic [VW-1:0]        w_side_y;
    logic [VW-1:0]        w_side_r;

    logic                 w_pv;
    logic [31:0]          w_pitch, w_roll_d;
    logic signed [VW-1:0] w_mag_p;

    logic                 r_ov;
    eyfz_pkg::t_out_word  r_od;
    logic [31:0]          w_yaw_d;

    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;

    eyfz_rot #(.STEPS(CORDIC_STEPS)) u_rot_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_ang(i_data.in_yaw), .o_valid(w_rv_y), .o_cos(w_cy), .o_sin(w_sy)
    );
    eyfz_rot #(.STEPS(CORDIC_STEPS)) u_rot_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_ang(i_data.in_pitch), .o_valid(w_rv_p), .o_cos(w_cp), .o_sin(w_sp)
    );
    eyfz_rot #(.STEPS(CORDIC_STEPS)) u_rot_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_ang(i_data.in_roll), .o_valid(w_rv_r), .o_cos(w_cr), .o_sin(w_sr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_rv_y && w_rv_p && w_rv_r;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= w_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_f00  <= eyfz_pkg::qmul(MW'(w_cp), MW'(w_cy));
            r1_f20  <= eyfz_pkg::qmul(MW'(w_sp), MW'(w_cy));
            r1_spsy <= eyfz_pkg::qmul(MW'(w_sp), MW'(w_sy));
            r1_f10  <= -MW'(w_sy);
            r1_cp   <= MW'(w_cp);
            r1_cr   <= MW'(w_cr);
            r1_sr   <= MW'(w_sr);

            r2_f00 <= r1_f00;
            r2_f10 <= r1_f10;
            r2_f20 <= r1_f20;
            r2_p1  <= eyfz_pkg::qmul(r1_spsy, r1_cr);
            r2_p2  <= eyfz_pkg::qmul(r1_cp, r1_sr);
            r2_p3  <= eyfz_pkg::qmul(r1_spsy, r1_sr);
            r2_p4  <= eyfz_pkg::qmul(r1_cp, r1_cr);

            r3_f00  <= VW'(r2_f00);
            r3_f10  <= VW'(r2_f10);
            r3_nf20 <= VW'(-r2_f20);
            r3_f21  <= VW'(-(r2_p1 + r2_p2));
            r3_f22  <= VW'(r2_p3 - r2_p4);
        end
    end

    eyfz_vec #(.STEPS(CORDIC_STEPS), .SIDE_W(VW)) u_vec_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v3),
        .i_x(r3_f00), .i_y(r3_f10), .i_side(r3_nf20),
        .o_valid(w_yv), .o_ang(w_yaw), .o_mag(w_mag), .o_side(w_side_y)
    );
    eyfz_vec #(.STEPS(CORDIC_STEPS), .SIDE_W(VW)) u_vec_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v3),
        .i_x(r3_f22), .i_y(r3_f21), .i_side(r3_f00),
        .o_valid(w_rv), .o_ang(w_roll), .o_mag(w_mag_unused_r), .o_side(w_side_r)
    );

    assign w_nf20 = signed'(w_side_y);

    eyfz_vec #(.STEPS(CORDIC_STEPS), .SIDE_W(64)) u_vec_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_yv && w_rv),
        .i_x(w_mag), .i_y(w_nf20), .i_side({w_yaw, w_roll}),
        .o_valid(w_pv), .o_ang(w_pitch), .o_mag(w_mag_p), .o_side({w_yaw_d, w_roll_d})
    );

    function automatic logic signed [AB-1:0] round_phase(input logic [31:0] z);
        logic [31:0] s;
        s = z + HALF;
        return signed'(s[31:32-AB]);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_od.out_yaw   <= round_phase(w_yaw_d);
            r_od.out_pitch <= round_phase(w_pitch);
            r_od.out_roll  <= round_phase(w_roll_d);
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable({r_v1, r_v2, r_v3}))
        else $error("multiply stages moved during a stall");

    a_terms_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r3_f22 < 262144 && r3_f22 > -262144 &&
                  r3_f21 < 262144 && r3_f21 > -262144 &&
                  w_side_r == w_side_r && w_mag_p == w_mag_p &&
                  w_mag_unused_r == w_mag_unused_r))
        else $error("matrix term out of range");

endmodule

[hdl/eyfz_rot.sv]
// Pipelined rotation CORDIC that gives the cosine and sine of one binary angle.
module eyfz_rot #(
    parameter int STEPS = eyfz_pkg::CORDIC_STEPS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic signed [eyfz_pkg::ANGLE_BITS-1:0]  i_ang,
    output logic                                    o_valid,
    output logic signed [eyfz_pkg::ROT_W-1:0]       o_cos,
    output logic signed [eyfz_pkg::ROT_W-1:0]       o_sin
);
    localparam int AB = eyfz_pkg::ANGLE_BITS;
    localparam int RW = eyfz_pkg::ROT_W;
    localparam int ZW = eyfz_pkg::Z_W;

    logic signed [RW-1:0] r_x [0:STEPS];
    logic signed [RW-1:0] r_y [0:STEPS];
    logic signed [ZW-1:0] r_z [0:STEPS];
    logic                 r_neg [0:STEPS];
    logic [STEPS:0]       r_v;

    logic [31:0] w_ph;
    logic [31:0] w_turn;
    logic        w_neg;
    logic [31:0] w_ph2;

    assign w_ph   = {i_ang, {(32-AB){1'b0}}};
    assign w_turn = w_ph + 32'h4000_0000;
    assign w_neg  = w_turn[31];
    assign w_ph2  = w_neg ? (w_ph + 32'h8000_0000) : w_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= RW'(eyfz_pkg::GAIN_Q16);
            r_y[0]   <= '0;
            r_z[0]   <= ZW'(signed'(w_ph2));
            r_neg[0] <= w_neg;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic signed [ZW-1:0] w_at;
        assign w_at = signed'({{(ZW-32){1'b0}}, eyfz_pkg::atan_entry(k)});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - w_at;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + w_at;
                end
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_cos   = r_neg[STEPS] ? -r_x[STEPS] : r_x[STEPS];
    assign o_sin   = r_neg[STEPS] ? -r_y[STEPS] : r_y[STEPS];

endmodule

[hdl/eyfz_vec.sv]
// Pipelined vectoring CORDIC that gives the phase and length of a vector and carries a side word along.
module eyfz_vec #(
    parameter int STEPS  = eyfz_pkg::CORDIC_STEPS,
    parameter int SIDE_W = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [eyfz_pkg::VEC_W-1:0]   i_x,
    input  logic signed [eyfz_pkg::VEC_W-1:0]   i_y,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_valid,
    output logic [31:0]                         o_ang,
    output logic signed [eyfz_pkg::VEC_W-1:0]   o_mag,
    output logic [SIDE_W-1:0]                   o_side
);
    localparam int VW = eyfz_pkg::VEC_W;
    localparam int PW = VW + 18;

    logic signed [VW-1:0] r_x [0:STEPS];
    logic signed [VW-1:0] r_y [0:STEPS];
    logic [31:0]          r_z [0:STEPS];
    logic                 r_zero [0:STEPS];
    logic [SIDE_W-1:0]    r_side [0:STEPS];
    logic [STEPS+1:0]     r_v;
    logic [31:0]          r_ang;
    logic signed [VW-1:0] r_mag;
    logic [SIDE_W-1:0]    r_oside;

    logic                 w_zero;
    logic                 w_flip;
    logic signed [PW-1:0] w_prod;

    assign w_zero = (i_x == '0) && (i_y == '0);
    assign w_flip = i_x < 0;
    assign w_prod = PW'(r_x[STEPS]) * PW'(eyfz_pkg::GAIN_Q16) + PW'(32768);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= w_flip ? -i_x : i_x;
            r_y[0]    <= w_flip ? -i_y : i_y;
            r_z[0]    <= w_flip ? 32'h8000_0000 : 32'h0;
            r_zero[0] <= w_zero;
            r_side[0] <= i_side;
            r_ang     <= r_zero[STEPS] ? 32'h0 : r_z[STEPS];
            r_mag     <= r_zero[STEPS] ? '0 : w_prod[VW+15:16];
            r_oside   <= r_side[STEPS];
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + eyfz_pkg::atan_entry(k);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - eyfz_pkg::atan_entry(k);
                end
                r_zero[k+1] <= r_zero[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[STEPS+1];
    assign o_ang   = r_ang;
    assign o_mag   = r_mag;
    assign o_side  = r_oside;

endmodule
